// ===== sv/pbbd_pkg.sv =====
package pbbd_pkg;

	localparam int DEF_NUM_BANDS = 16;

	localparam logic [3:0] TENTHS_RESET = 4'd7;
	localparam logic [8:0] PEAK_RESET   = 9'd50;

	typedef struct packed {
		logic [3:0] band_index;
		logic [7:0] power;
	} sample_t;

	typedef struct packed {
		logic       beat;
		logic [8:0] peak_level;
	} result_t;

	typedef struct packed {
		logic [7:0] floor_level;
		logic [8:0] peak_track;
		logic [7:0] last_power;
		logic [7:0] older_power;
	} band_state_t;

endpackage

// ===== sv/pbbd_state.sv =====
module pbbd_state #(
	parameter int NUM_BANDS = pbbd_pkg::DEF_NUM_BANDS,
	parameter int IDX_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [IDX_W-1:0]        idx,
	input  logic                    wr_en,
	input  pbbd_pkg::band_state_t   wr_data,
	output pbbd_pkg::band_state_t   rd_data
);

	pbbd_pkg::band_state_t bank_q [NUM_BANDS];

	assign rd_data = bank_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BANDS; b++) begin
				bank_q[b].floor_level <= '0;
				bank_q[b].peak_track  <= pbbd_pkg::PEAK_RESET;
				bank_q[b].last_power  <= '0;
				bank_q[b].older_power <= '0;
			end
		end else if (wr_en) begin
			bank_q[idx] <= wr_data;
		end
	end

endmodule

// ===== sv/pbbd_update.sv =====
module pbbd_update (
	input  pbbd_pkg::band_state_t cur,
	input  logic [7:0]            power,
	input  logic [3:0]            tenths,
	output pbbd_pkg::band_state_t nxt,
	output logic                  beat
);

	logic [8:0]  lhs_max;
	logic        local_max;
	logic [10:0] peak_sum;
	logic [8:0]  peak_new;
	logic [7:0]  floor_dec;
	logic [11:0] power_x10;
	logic [13:0] thresh;

	always_comb begin
		// previous sample stood above the current one by a quarter of the peak and above the one before it
		lhs_max   = {1'b0, power} + {2'b0, cur.peak_track[8:2]};
		local_max = (lhs_max < {1'b0, cur.last_power}) &&
			(cur.last_power > cur.older_power);

		if ({1'b0, cur.last_power} > cur.peak_track)
			peak_sum = 11'(3 * cur.peak_track) + {2'b0, cur.last_power, 1'b0};
		else
			peak_sum = 11'(3 * cur.peak_track) + {3'b0, cur.last_power};

		peak_new = local_max ? peak_sum[10:2] : cur.peak_track;

		if (power < cur.floor_level)
			floor_dec = power;
		else if (cur.floor_level != 8'd0)
			floor_dec = cur.floor_level - 8'd1;
		else
			floor_dec = cur.floor_level;

		power_x10 = 12'(power * 10);
		thresh    = 14'(floor_dec * 10) + 14'(tenths) * 14'(peak_new);
		beat      = {2'b0, power_x10} > thresh;

		nxt.peak_track  = peak_new;
		nxt.floor_level = beat ? power : floor_dec;
		nxt.older_power = cur.last_power;
		nxt.last_power  = power;
	end

endmodule

// ===== sv/per_band_beat_detector.sv =====
// Per-band beat detector. Each beat on the sample channel carries a band index and that band's
// power; each yields exactly one result (beat flag and the band's updated peak level), in order.
// One sample is taken every cycle unless result_stall holds the pipeline: the sample sits in
// an input register, the band's state is read from a register bank, updated in one combinational
// pass and written back on the same edge the result register loads, so samples of the same band
// may follow each other back to back. The result is registered: it loads into the result register
// as its sample leaves the input register. A band index at or above NUM_BANDS returns beat 0 and
// peak level 0 and leaves all state alone. Write cfg_wr_data (trigger tenths, reset 7) only while
// the block is idle.
module per_band_beat_detector #(
	parameter int NUM_BANDS = pbbd_pkg::DEF_NUM_BANDS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  pbbd_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_stall,
	output pbbd_pkg::result_t result,
	input  logic              cfg_wr_en,
	input  logic [3:0]        cfg_wr_data
);

	localparam int IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

	logic [3:0]            tenths_q;
	logic                  valid_s1;
	pbbd_pkg::sample_t     sample_s1;
	logic                  valid_s2;
	pbbd_pkg::result_t     result_s2;

	logic                  adv_s2;
	logic                  adv_s1;
	logic                  in_range;
	logic [IDX_W+3:0]      idx_wide;
	logic [IDX_W-1:0]      idx;
	pbbd_pkg::band_state_t cur_state;
	pbbd_pkg::band_state_t nxt_state;
	logic                  beat_c;

	assign adv_s2       = !valid_s2 || !result_stall;
	assign adv_s1       = valid_s1 && adv_s2;
	assign sample_stall = valid_s1 && !adv_s2;

	assign in_range = 32'(sample_s1.band_index) < NUM_BANDS;
	assign idx_wide = {{IDX_W{1'b0}}, sample_s1.band_index};
	assign idx      = idx_wide[IDX_W-1:0];

	pbbd_state #(
		.NUM_BANDS (NUM_BANDS),
		.IDX_W     (IDX_W)
	) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.idx     (idx),
		.wr_en   (adv_s1 && in_range),
		.wr_data (nxt_state),
		.rd_data (cur_state)
	);

	pbbd_update u_update (
		.cur    (cur_state),
		.power  (sample_s1.power),
		.tenths (tenths_q),
		.nxt    (nxt_state),
		.beat   (beat_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tenths_q <= pbbd_pkg::TENTHS_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_wr_en)
				tenths_q <= cfg_wr_data;
			if (!sample_stall)
				valid_s1 <= sample_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall)
			sample_s1 <= sample;
		if (adv_s1) begin
			// out-of-range band: report zeros
			result_s2.beat       <= in_range && beat_c;
			result_s2.peak_level <= in_range ? nxt_state.peak_track : 9'd0;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule
